@@ hw/rtl/scsfp_pkg.sv @@
// Package for the sum-checked sensor frame parser.
// Holds frame geometry constants, start bytes, status codes and the state type.
// No dependencies.
package scsfp_pkg;

    // Frame geometry.
    localparam int FRAME_LEN   = 32;
    localparam int STORE_DEPTH = 40;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int MAX_WORDS   = 17;
    localparam int RAW_WORDS   = (FRAME_LEN > 6) ? (FRAME_LEN - 6) / 2 : 0;
    localparam int NUM_WORDS   = (RAW_WORDS > MAX_WORDS) ? MAX_WORDS : RAW_WORDS;

    // Field widths.
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 6;
    localparam int SUM_W   = 16;
    localparam int INDEX_W = 5;
    localparam int WORD_W  = 16;

    // Byte positions inside the frame.
    localparam logic [COUNT_W-1:0] CHK_HI_POS = COUNT_W'(FRAME_LEN - 2);
    localparam logic [COUNT_W-1:0] STORE_END  = COUNT_W'(STORE_DEPTH);
    localparam logic [STORE_AW-1:0] PAYLOAD_BASE = STORE_AW'(4);
    localparam logic [INDEX_W-1:0] LAST_WORD  = INDEX_W'((NUM_WORDS > 0) ? NUM_WORDS - 1 : 0);

    // Start pair.
    localparam logic [BYTE_W-1:0] START_A = 8'h42;
    localparam logic [BYTE_W-1:0] START_B = 8'h4D;

    // Result status codes.
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    // Parser states.
    typedef enum logic [3:0] {
        ST_HUNT1,
        ST_HUNT2,
        ST_LENH,
        ST_LENL,
        ST_RECV,
        ST_LAST,
        ST_RD_HI,
        ST_RD_LO,
        ST_WORD
    } t_state;

endpackage

@@ hw/rtl/scsfp_byte_if.sv @@
// Request channel carrying one received serial byte.
// Depends on scsfp_pkg for the byte width.
interface scsfp_byte_if;
    logic                           valid;
    logic                           ready;
    logic [scsfp_pkg::BYTE_W-1:0]   rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ hw/rtl/scsfp_result_if.sv @@
// Request channel carrying one parsed result word or an error report.
// Depends on scsfp_pkg for the field widths.
interface scsfp_result_if;
    logic                           valid;
    logic                           ready;
    logic                           status;
    logic [scsfp_pkg::INDEX_W-1:0]  word_index;
    logic [scsfp_pkg::WORD_W-1:0]   word_value;
    logic                           last;

    modport source (output valid, output status, output word_index, output word_value,
                    output last, input ready);
    modport sink   (input valid, input status, input word_index, input word_value,
                    input last, output ready);
endinterface

@@ hw/rtl/scsfp_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module scsfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 40
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/sum_checked_sensor_frame_parser.sv @@
// Sum-checked sensor frame parser: hunts for the start pair 0x42 0x4D, stores a
// fixed-length frame in a small RAM and checks its 16-bit byte sum against the
// trailing big-endian checksum. Frame bytes are taken one per cycle, but the last
// byte waits for a free result output. A matching frame is then read back from
// the RAM and sent as one result per payload word: a high-byte read and a low-byte
// read on the single RAM read port, then the output load, which waits for a free
// output. No byte is taken during readout. A mismatch gives one error result at once.
// Depends on scsfp_pkg, scsfp_byte_if, scsfp_result_if and scsfp_ram.
module sum_checked_sensor_frame_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    scsfp_byte_if.sink            i_rx,
    scsfp_result_if.source        o_res
);

    // Control registers.
    scsfp_pkg::t_state                   r_state, n_state;
    logic [scsfp_pkg::COUNT_W-1:0]       r_count, n_count;
    logic [scsfp_pkg::SUM_W-1:0]         r_sum,   n_sum;
    logic [scsfp_pkg::BYTE_W-1:0]        r_chk_hi, n_chk_hi;
    logic [scsfp_pkg::INDEX_W-1:0]       r_word,  n_word;
    logic [scsfp_pkg::BYTE_W-1:0]        r_hi,    n_hi;

    // Output register.
    logic                                r_out_valid, n_out_valid;
    logic                                r_out_status, n_out_status;
    logic [scsfp_pkg::INDEX_W-1:0]       r_out_index, n_out_index;
    logic [scsfp_pkg::WORD_W-1:0]        r_out_value, n_out_value;
    logic                                r_out_last, n_out_last;

    // RAM and handshake signals.
    logic                                ram_we;
    logic [scsfp_pkg::STORE_AW-1:0]      ram_waddr;
    logic                                ram_re;
    logic [scsfp_pkg::STORE_AW-1:0]      ram_raddr;
    logic [scsfp_pkg::BYTE_W-1:0]        ram_rdata;
    logic                                in_ready;
    logic                                accept;
    logic                                out_free;
    logic                                load_out;
    logic [scsfp_pkg::BYTE_W-1:0]        rx;
    logic [scsfp_pkg::WORD_W-1:0]        sent;
    logic [scsfp_pkg::STORE_AW-1:0]      pair_addr;

    scsfp_ram #(
        .WIDTH (scsfp_pkg::BYTE_W),
        .DEPTH (scsfp_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (rx),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rx        = i_rx.rx_byte;
    assign out_free  = !r_out_valid || o_res.ready;
    assign accept    = i_rx.valid && in_ready;
    assign ram_waddr = r_count[scsfp_pkg::STORE_AW-1:0];
    assign sent      = {r_chk_hi, rx};
    assign pair_addr = scsfp_pkg::PAYLOAD_BASE + {r_word, 1'b0};

    // Next state, frame bookkeeping and readout sequencing.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_sum        = r_sum;
        n_chk_hi     = r_chk_hi;
        n_word       = r_word;
        n_hi         = r_hi;
        n_out_status = r_out_status;
        n_out_index  = r_out_index;
        n_out_value  = r_out_value;
        n_out_last   = r_out_last;
        in_ready     = 1'b0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_raddr    = pair_addr;
        load_out     = 1'b0;

        case (r_state)
            scsfp_pkg::ST_HUNT1, scsfp_pkg::ST_HUNT2, scsfp_pkg::ST_LENH,
            scsfp_pkg::ST_LENL, scsfp_pkg::ST_RECV: begin
                in_ready = 1'b1;
            end
            scsfp_pkg::ST_LAST: begin
                in_ready = out_free;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase

        // Storing a byte: RAM write, sum and count update.
        if (accept && !(r_state == scsfp_pkg::ST_HUNT1 && rx != scsfp_pkg::START_A)
                   && !(r_state == scsfp_pkg::ST_HUNT2 && rx != scsfp_pkg::START_B)) begin
            ram_we  = (r_count < scsfp_pkg::STORE_END);
            n_count = r_count + scsfp_pkg::COUNT_W'(1);
            if (r_count < scsfp_pkg::CHK_HI_POS) begin
                n_sum = r_sum + scsfp_pkg::SUM_W'(rx);
            end
            if (r_count == scsfp_pkg::CHK_HI_POS) begin
                n_chk_hi = rx;
            end
        end

        case (r_state)
            scsfp_pkg::ST_HUNT1: begin
                n_count = (accept && rx == scsfp_pkg::START_A) ?
                          scsfp_pkg::COUNT_W'(1) : '0;
                n_sum   = (accept && rx == scsfp_pkg::START_A) ?
                          scsfp_pkg::SUM_W'(rx) : '0;
                if (accept && rx == scsfp_pkg::START_A) begin
                    n_state = scsfp_pkg::ST_HUNT2;
                end
            end
            scsfp_pkg::ST_HUNT2: begin
                if (accept) begin
                    if (rx == scsfp_pkg::START_B) begin
                        n_state = scsfp_pkg::ST_LENH;
                    end else begin
                        n_state = scsfp_pkg::ST_HUNT1;
                        n_count = '0;
                        n_sum   = '0;
                    end
                end
            end
            scsfp_pkg::ST_LENH: begin
                if (accept) begin
                    n_state = scsfp_pkg::ST_LENL;
                end
            end
            scsfp_pkg::ST_LENL: begin
                if (accept) begin
                    n_state = scsfp_pkg::ST_RECV;
                end
            end
            scsfp_pkg::ST_RECV: begin
                if (accept && r_count >= scsfp_pkg::CHK_HI_POS) begin
                    n_state = scsfp_pkg::ST_LAST;
                end
            end
            scsfp_pkg::ST_LAST: begin
                if (accept) begin
                    n_count = '0;
                    n_sum   = '0;
                    n_word  = '0;
                    if (sent != r_sum) begin
                        // Checksum mismatch: one error result.
                        load_out     = 1'b1;
                        n_out_status = scsfp_pkg::STATUS_BAD;
                        n_out_index  = '0;
                        n_out_value  = '0;
                        n_out_last   = 1'b1;
                        n_state      = scsfp_pkg::ST_HUNT1;
                    end else if (scsfp_pkg::NUM_WORDS == 0) begin
                        n_state = scsfp_pkg::ST_HUNT1;
                    end else begin
                        n_state = scsfp_pkg::ST_RD_HI;
                    end
                end
            end
            scsfp_pkg::ST_RD_HI: begin
                // Fetch the high byte of the current word.
                ram_re    = 1'b1;
                ram_raddr = pair_addr;
                n_state   = scsfp_pkg::ST_RD_LO;
            end
            scsfp_pkg::ST_RD_LO: begin
                // High byte arrives; fetch the low byte.
                n_hi      = ram_rdata;
                ram_re    = 1'b1;
                ram_raddr = pair_addr + scsfp_pkg::STORE_AW'(1);
                n_state   = scsfp_pkg::ST_WORD;
            end
            scsfp_pkg::ST_WORD: begin
                // Low byte held in the RAM read register until the output is free.
                if (out_free) begin
                    load_out     = 1'b1;
                    n_out_status = scsfp_pkg::STATUS_OK;
                    n_out_index  = r_word;
                    n_out_value  = {r_hi, ram_rdata};
                    n_out_last   = (r_word == scsfp_pkg::LAST_WORD);
                    n_word       = r_word + scsfp_pkg::INDEX_W'(1);
                    n_state      = (r_word == scsfp_pkg::LAST_WORD) ?
                                   scsfp_pkg::ST_HUNT1 : scsfp_pkg::ST_RD_HI;
                end
            end
            default: begin
                n_state = scsfp_pkg::ST_HUNT1;
                n_count = '0;
                n_sum   = '0;
            end
        endcase

        n_out_valid = load_out || (r_out_valid && !o_res.ready);
    end

    // Control state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= scsfp_pkg::ST_HUNT1;
            r_count     <= '0;
            r_sum       <= '0;
            r_word      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_word      <= n_word;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_chk_hi     <= n_chk_hi;
        r_hi         <= n_hi;
        r_out_status <= n_out_status;
        r_out_index  <= n_out_index;
        r_out_value  <= n_out_value;
        r_out_last   <= n_out_last;
    end

    assign i_rx.ready       = in_ready;
    assign o_res.valid      = r_out_valid;
    assign o_res.status     = r_out_status;
    assign o_res.word_index = r_out_index;
    assign o_res.word_value = r_out_value;
    assign o_res.last       = r_out_last;

endmodule

@@ tb/sum_checked_sensor_frame_parser_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the sum-checked sensor frame parser: feeds byte requests,
// predicts payload words and checksum error reports, and compares every result.
// Depends on scsfp_pkg, scsfp_byte_if, scsfp_result_if and the parser RTL.
module sum_checked_sensor_frame_parser_tb;
    import scsfp_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_BYTES = 380;
    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 40;
    localparam int MAX_GAP      = 18;
    // Bytes covered by the checksum: everything before the two trailing bytes.
    localparam int SUM_END      = FRAME_LEN - 2;

    // Payload fill patterns for generated frames.
    localparam int FILL_ZERO   = 0;
    localparam int FILL_ONES   = 1;
    localparam int FILL_RANDOM = 2;

    typedef struct packed {
        logic               status;
        logic [INDEX_W-1:0] word_index;
        logic [WORD_W-1:0]  word_value;
        logic               last;
    } word_rec_t;

    // Tracks the parser's framing state and holds the words it should emit.
    class frame_tracker;
        t_state             phase;
        logic [COUNT_W-1:0] count;
        logic [SUM_W-1:0]   sum;
        logic [BYTE_W-1:0]  store [STORE_DEPTH];
        word_rec_t          expected_words [$];
        int unsigned        mismatches;
        int unsigned        data_words;
        int unsigned        bad_frames;

        function new();
            mismatches = 0;
            data_words = 0;
            bad_frames = 0;
            restart();
        endfunction

        function void restart();
            phase = ST_HUNT1;
            count = '0;
            sum   = '0;
        endfunction

        // Store the byte, add it to the sum unless it is a checksum byte.
        function void keep(input logic [BYTE_W-1:0] b);
            if (int'(count) < STORE_DEPTH) begin
                store[count] = b;
            end
            if (int'(count) + 2 < FRAME_LEN) begin
                sum = sum + SUM_W'(b);
            end
            count = count + 1'b1;
        endfunction

        function logic [BYTE_W-1:0] stored_byte(input int pos);
            return (pos < STORE_DEPTH) ? store[pos] : '0;
        endfunction

        // Advance the framing state by one accepted byte request.
        function void note_byte(input logic [BYTE_W-1:0] b);
            logic [WORD_W-1:0] sent;
            word_rec_t         rec;
            int                k;
            case (phase)
                ST_HUNT2: begin
                    if (b == START_B) begin
                        keep(b);
                        phase = ST_LENH;
                    end else begin
                        restart();
                    end
                end
                ST_LENH: begin
                    keep(b);
                    phase = ST_LENL;
                end
                ST_LENL: begin
                    keep(b);
                    phase = ST_RECV;
                end
                ST_RECV: begin
                    keep(b);
                    if (int'(count) + 1 >= FRAME_LEN) begin
                        phase = ST_LAST;
                    end
                end
                ST_LAST: begin
                    keep(b);
                    sent = {stored_byte(FRAME_LEN - 2), b};
                    if (sent == sum) begin
                        for (k = 0; k < NUM_WORDS; k++) begin
                            rec.status     = STATUS_OK;
                            rec.word_index = INDEX_W'(k);
                            rec.word_value = {stored_byte(4 + 2 * k), stored_byte(5 + 2 * k)};
                            rec.last       = (k == NUM_WORDS - 1);
                            expected_words.push_back(rec);
                        end
                    end else begin
                        rec.status     = STATUS_BAD;
                        rec.word_index = '0;
                        rec.word_value = '0;
                        rec.last       = 1'b1;
                        expected_words.push_back(rec);
                    end
                    restart();
                end
                default: begin
                    restart();
                    if (b == START_A) begin
                        keep(b);
                        phase = ST_HUNT2;
                    end
                end
            endcase
        endfunction

        function void compare(input string field, input int unsigned want,
                              input int unsigned got);
            if (want != got) begin
                mismatches++;
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, field, want, got);
            end
        endfunction

        // Match one accepted result against the oldest expected word.
        function void check_word(input word_rec_t got);
            word_rec_t want;
            if (expected_words.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual status %0d %s",
                         $time, got.status, "index/value/last follow");
                $display("    index %0d value 0x%h last %0d",
                         got.word_index, got.word_value, got.last);
                return;
            end
            want = expected_words.pop_front();
            if (want.status == STATUS_OK) begin
                data_words++;
            end else begin
                bad_frames++;
            end
            compare("status", want.status, got.status);
            compare("word_index", want.word_index, got.word_index);
            compare("word_value", want.word_value, got.word_value);
            compare("last", want.last, got.last);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    int unsigned cycle_count = 0;
    int unsigned bytes_sent  = 0;
    int unsigned frames_sent = 0;
    bit          src_steady  = 0;
    bit          sink_steady = 0;
    frame_tracker tracker;

    scsfp_byte_if   rx_ch ();
    scsfp_result_if res_ch ();

    sum_checked_sensor_frame_parser uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Offer one byte request after a random gap and wait for it to be taken.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if ($urandom_range(0, 63) == 0) begin
            src_steady = ~src_steady;
        end
        gap = src_steady ? 0 : $urandom_range(0, MAX_GAP);
        repeat (gap) begin
            @(negedge i_clk);
            rx_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge i_clk); while (!rx_ch.ready);
        tracker.note_byte(b);
        bytes_sent++;
    endtask

    // Build a full frame with a correct or corrupted checksum, optionally dropping a byte.
    task automatic send_frame(input int fill, input bit corrupt, input bit truncate);
        logic [BYTE_W-1:0] frame_bytes [FRAME_LEN];
        logic [SUM_W-1:0]  chk;
        int                skip;
        int                i;
        frame_bytes[0] = START_A;
        frame_bytes[1] = START_B;
        for (i = 2; i < SUM_END; i++) begin
            case (fill)
                FILL_ZERO: frame_bytes[i] = 8'h00;
                FILL_ONES: frame_bytes[i] = 8'hFF;
                default:   frame_bytes[i] = BYTE_W'($urandom);
            endcase
        end
        chk = '0;
        for (i = 0; i < SUM_END; i++) begin
            chk = chk + SUM_W'(frame_bytes[i]);
        end
        if (corrupt) begin
            chk = chk ^ (SUM_W'(1) << $urandom_range(0, SUM_W - 1));
        end
        frame_bytes[SUM_END]     = chk[15:8];
        frame_bytes[SUM_END + 1] = chk[7:0];
        skip = truncate ? $urandom_range(2, FRAME_LEN - 1) : FRAME_LEN;
        for (i = 0; i < FRAME_LEN; i++) begin
            if (i != skip) begin
                send_byte(frame_bytes[i]);
            end
        end
        frames_sent++;
    endtask

    // Result side: random ready gaps, one long hold-off, and a check per result.
    initial begin
        word_rec_t   got;
        int          gap;
        int unsigned taken;
        bit          held;
        taken = 0;
        held  = 0;
        res_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (!held && taken == HOLD_AFTER) begin
                // Hold the output long enough for the parser to back up onto its input.
                held = 1;
                @(negedge i_clk);
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if ($urandom_range(0, 31) == 0) begin
                sink_steady = ~sink_steady;
            end
            gap = sink_steady ? 0 : $urandom_range(0, MAX_GAP);
            repeat (gap) begin
                @(negedge i_clk);
                res_ch.ready <= 1'b0;
            end
            @(negedge i_clk);
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
            got.status     = res_ch.status;
            got.word_index = res_ch.word_index;
            got.word_value = res_ch.word_value;
            got.last       = res_ch.last;
            tracker.check_word(got);
            taken++;
        end
    end

    // Main sequence: reset, directed cases, random frames, drain.
    initial begin
        int unsigned random_start;
        int          pick;
        tracker       = new();
        i_rst_n       = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Bytes other than the first start byte are ignored while hunting.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(START_B);
        // A repeated first start byte and a zero both count as a wrong second byte.
        send_byte(START_A);
        send_byte(START_A);
        send_byte(START_A);
        send_byte(8'h00);
        // Zero payload and length, all-ones payload and length, then a checksum mismatch.
        send_frame(FILL_ZERO, 1'b0, 1'b0);
        send_frame(FILL_ONES, 1'b0, 1'b0);
        send_frame(FILL_RANDOM, 1'b1, 1'b0);

        // Mostly well-formed frames, mixed with noise, broken starts and short frames.
        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES) begin
            pick = $urandom_range(0, 15);
            case (pick)
                0, 1: begin
                    repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom));
                end
                2: begin
                    send_byte(START_A);
                    send_byte(BYTE_W'($urandom));
                end
                3: send_frame(FILL_RANDOM, 1'b0, 1'b1);
                4, 5: send_frame(FILL_RANDOM, 1'b1, 1'b0);
                default: send_frame(FILL_RANDOM, 1'b0, 1'b0);
            endcase
        end
        @(negedge i_clk);
        rx_ch.valid <= 1'b0;

        while (tracker.expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run sent %0d bytes: %0d generated frames plus noise and broken start pairs.",
                 bytes_sent, frames_sent);
        $display("Checked %0d payload words and %0d checksum error reports, one long hold.",
                 tracker.data_words, tracker.bad_frames);
        if (tracker.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/scsfp_pkg.sv
hw/rtl/scsfp_byte_if.sv
hw/rtl/scsfp_result_if.sv
hw/rtl/scsfp_ram.sv
hw/rtl/sum_checked_sensor_frame_parser.sv
tb/sum_checked_sensor_frame_parser_tb.sv
